@@ design/cit_pkg.sv @@
package cit_pkg;

  // Fixed field widths of the item ports
  localparam int unsigned OP_W     = 2;
  localparam int unsigned TID_W    = 16;
  localparam int unsigned STATE_W  = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LIVE_W   = 5;

  // Operation codes
  localparam logic [OP_W-1:0] OP_CREATE = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
  localparam logic [OP_W-1:0] OP_SET    = 2'd2;

  // Status codes
  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd2;

  // Entry state written by create
  localparam logic [STATE_W-1:0] ENTRY_READY = 2'd0;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_RUN,
    FSM_DONE
  } fsm_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_WRITE,
    CELL_SET,
    CELL_SHIFT
  } cell_cmd_t;

  typedef struct packed {
    cell_cmd_t          cmd;
    logic [STATE_W-1:0] wr_state;
  } cell_ctrl_t;

endpackage

@@ design/cit_cell.sv @@
module cit_cell #(
  parameter int unsigned ID_WIDTH = 16,
  parameter int unsigned IDX_W    = 4,
  parameter int unsigned INDEX    = 0
) (
  input  logic                         clk,
  input  cit_pkg::cell_ctrl_t          ctrl,
  input  logic [IDX_W-1:0]             pos,
  input  logic [ID_WIDTH-1:0]          new_id,
  input  logic [ID_WIDTH-1:0]          key,
  input  logic                         key_ok,
  input  logic [ID_WIDTH-1:0]          nbr_id,
  input  logic [cit_pkg::STATE_W-1:0]  nbr_state,
  output logic [ID_WIDTH-1:0]          id,
  output logic [cit_pkg::STATE_W-1:0]  state,
  output logic                         match
);
  import cit_pkg::*;

  localparam logic [IDX_W-1:0] MY_POS = IDX_W'(INDEX);

  logic [ID_WIDTH-1:0] id_r;
  logic [STATE_W-1:0]  state_r;

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      CELL_WRITE: begin
        if (pos == MY_POS) begin
          id_r    <= new_id;
          state_r <= ENTRY_READY;
        end
      end
      CELL_SET: begin
        if (pos == MY_POS) begin
          state_r <= ctrl.wr_state;
        end
      end
      CELL_SHIFT: begin
        // cells at and above the removed slot take their upper neighbor
        if (MY_POS >= pos) begin
          id_r    <= nbr_id;
          state_r <= nbr_state;
        end
      end
      default: begin
      end
    endcase
  end

  assign id    = id_r;
  assign state = state_r;
  assign match = key_ok && (id_r == key);

endmodule

@@ design/compacting_id_table.sv @@
// Ordering: create and unused op go through RUN and DONE to the output register;
//   remove and set state stay in RUN while scanning slots up to a hit (all
//   live slots on a miss), then go through DONE to the output register.
// Items go one at a time; DONE waits until the output register is free, and the
//   next item is taken in the first cycle that the result sits in the output register.
// Reset: rst_n low clears live count to 0, id counter to 1, and the control.
module compacting_id_table #(
  parameter int unsigned MAX_ENTRIES = 16,
  parameter int unsigned ID_WIDTH    = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_op,
  input  logic [15:0] in_target_id,
  input  logic [1:0]  in_new_state,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [15:0] out_assigned_id,
  output logic [4:0]  out_live_count
);
  import cit_pkg::*;

  // Index of a cell, and a count that can also hold MAX_ENTRIES
  localparam int unsigned IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int unsigned CNT_W = $clog2(MAX_ENTRIES + 1);
  // Width for comparing the 16-bit target against stored identifiers
  localparam int unsigned CMP_W = (ID_WIDTH > TID_W) ? ID_WIDTH : TID_W;
  localparam int unsigned CL_W  = (CNT_W > LIVE_W) ? CNT_W : LIVE_W;
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_ENTRIES);

  // Control state
  fsm_t                state_r, state_nxt;
  logic [CNT_W-1:0]    count_r, count_nxt;
  logic [ID_WIDTH-1:0] ctr_r, ctr_nxt;
  logic [CNT_W-1:0]    scan_r, scan_nxt;
  logic                out_valid_r, out_valid_nxt;

  // Latched item
  logic [OP_W-1:0]     op_r;
  logic [ID_WIDTH-1:0] key_r;
  logic                key_ok_r;
  logic [STATE_W-1:0]  nstate_r;

  // Pending result and output register
  logic [STATUS_W-1:0] res_status_r, res_status_nxt;
  logic [TID_W-1:0]    res_id_r, res_id_nxt;
  logic [STATUS_W-1:0] out_status_r;
  logic [TID_W-1:0]    out_id_r;
  logic [LIVE_W-1:0]   out_count_r;

  // Target compare: target is zero-extended; bits above ID_WIDTH never match
  logic [CMP_W-1:0]    tgt_ext;
  logic [ID_WIDTH-1:0] key_in;
  logic                key_ok_in;
  logic [CMP_W-1:0]    ctr_ext;
  logic [CL_W-1:0]     cnt_ext;

  assign tgt_ext   = CMP_W'(in_target_id);
  assign key_in    = tgt_ext[ID_WIDTH-1:0];
  assign key_ok_in = ((tgt_ext >> ID_WIDTH) == '0);
  assign ctr_ext   = CMP_W'(ctr_r);
  assign cnt_ext   = CL_W'(count_r);

  logic in_acc, out_free, run_done;
  logic [IDX_W-1:0] scan_idx;

  assign in_acc   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;
  assign scan_idx = scan_r[IDX_W-1:0];

  // Row of cells: cell i shifts down from cell i+1, the top one reloads itself
  cell_ctrl_t          cell_ctrl;
  logic [IDX_W-1:0]    cell_pos;
  logic [ID_WIDTH-1:0] cell_id    [MAX_ENTRIES];
  logic [STATE_W-1:0]  cell_state [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] cell_match;

  for (genvar gi = 0; gi < MAX_ENTRIES; gi++) begin : g_cell
    localparam int unsigned NB = (gi + 1 < MAX_ENTRIES) ? gi + 1 : gi;
    cit_cell #(
      .ID_WIDTH (ID_WIDTH),
      .IDX_W    (IDX_W),
      .INDEX    (gi)
    ) u_cell (
      .clk       (clk),
      .ctrl      (cell_ctrl),
      .pos       (cell_pos),
      .new_id    (ctr_r),
      .key       (key_r),
      .key_ok    (key_ok_r),
      .nbr_id    (cell_id[NB]),
      .nbr_state (cell_state[NB]),
      .id        (cell_id[gi]),
      .state     (cell_state[gi]),
      .match     (cell_match[gi])
    );
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      FSM_IDLE: if (in_valid) state_nxt = FSM_RUN;
      FSM_RUN:  if (run_done) state_nxt = FSM_DONE;
      FSM_DONE: if (out_free) state_nxt = FSM_IDLE;
      default:  state_nxt = FSM_IDLE;
    endcase
  end

  // Datapath control
  always_comb begin
    run_done       = 1'b0;
    cell_ctrl.cmd  = CELL_HOLD;
    cell_ctrl.wr_state = nstate_r;
    cell_pos       = scan_idx;
    count_nxt      = count_r;
    ctr_nxt        = ctr_r;
    scan_nxt       = scan_r;
    res_status_nxt = res_status_r;
    res_id_nxt     = res_id_r;
    case (state_r)
      FSM_IDLE: begin
        scan_nxt = '0;
      end
      FSM_RUN: begin
        res_status_nxt = STATUS_OK;
        res_id_nxt     = '0;
        case (op_r)
          OP_CREATE: begin
            run_done = 1'b1;
            if (count_r >= FULL_CNT) begin
              res_status_nxt = STATUS_FULL;
            end else begin
              cell_ctrl.cmd = CELL_WRITE;
              cell_pos      = count_r[IDX_W-1:0];
              res_id_nxt    = ctr_ext[TID_W-1:0];
              count_nxt     = count_r + CNT_W'(1);
              ctr_nxt       = ctr_r + ID_WIDTH'(1);
            end
          end
          OP_REMOVE, OP_SET: begin
            if (scan_r >= count_r) begin
              run_done       = 1'b1;
              res_status_nxt = STATUS_NOT_FOUND;
            end else if (cell_match[scan_idx]) begin
              run_done = 1'b1;
              if (op_r == OP_REMOVE) begin
                cell_ctrl.cmd = CELL_SHIFT;
                count_nxt     = count_r - CNT_W'(1);
              end else begin
                cell_ctrl.cmd = CELL_SET;
              end
            end else begin
              scan_nxt = scan_r + CNT_W'(1);
            end
          end
          default: run_done = 1'b1;
        endcase
      end
      default: begin
      end
    endcase
  end

  // Output register loads from the pending result
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (state_r == FSM_DONE && out_free) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= FSM_IDLE;
      count_r     <= '0;
      ctr_r       <= ID_WIDTH'(1);
      scan_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ctr_r       <= ctr_nxt;
      scan_r      <= scan_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r     <= in_op;
      key_r    <= key_in;
      key_ok_r <= key_ok_in;
      nstate_r <= in_new_state;
    end
    res_status_r <= res_status_nxt;
    res_id_r     <= res_id_nxt;
    if (state_r == FSM_DONE && out_free) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_count_r  <= cnt_ext[LIVE_W-1:0];
    end
  end

  assign in_stall        = (state_r != FSM_IDLE);
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_assigned_id = out_id_r;
  assign out_live_count  = out_count_r;

  // Live count never passes the table size
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FULL_CNT)
    else $error("live count above table size");

  // Scan pointer never passes the live count while running
  a_scan_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FSM_RUN |-> scan_r <= count_r)
    else $error("scan pointer past live entries");

  // A create with room grows the table by one and advances the id counter
  a_create_grow: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_RUN && op_r == OP_CREATE && count_r < FULL_CNT)
    |=> (count_r == $past(count_r) + CNT_W'(1)) && (ctr_r == $past(ctr_r) + ID_WIDTH'(1)))
    else $error("create did not grow table");

  // A finished item reaches the output register right after DONE is left
  a_done_out: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == FSM_DONE && out_free) |=> out_valid_r)
    else $error("result not delivered");

endmodule
